>>> design/bspl_pkg.sv
// Shared types, codes and constants for the BSP split insert and locate block.
package bspl_pkg;

    // Field widths fixed by the item format
    localparam int OP_W    = 2;
    localparam int COORD_W = 16;
    localparam int VAL_W   = 15;
    localparam int SLOT_W  = 16;
    localparam int NIDX_W  = 10;
    localparam int STAT_W  = 2;

    // Slot values at or above this link to another node
    localparam int LINK_BASE = 32768;

    // Defaults for the top-level parameters
    localparam int MAX_NODES_DEF   = 1024;
    localparam int DEPTH_LIMIT_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOCATE = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DEEP = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DEC,
        S_WNEW,
        S_DONE
    } state_t;

    // One table entry: split position, direction, left and right slots
    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic [SLOT_W-1:0]         slot_l;
        logic [SLOT_W-1:0]         slot_r;
    } node_t;

    // Root after reset or clear: pos (0.5, 0.5), dir (1, 1), both leaves 0
    localparam node_t ROOT_DEFAULT = '{
        px: 16'sd8192, py: 16'sd8192, dx: 16'sd16384, dy: 16'sd16384,
        slot_l: '0, slot_r: '0
    };

endpackage

>>> design/bspl_table.sv
// Node table memory with registered read and default-root substitution.
module bspl_table #(
    parameter int MAX_NODES = 1024,
    parameter int IDX_W     = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic                use_dflt,
    output bspl_pkg::node_t     rd_node,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  bspl_pkg::node_t     wr_node
);
    import bspl_pkg::*;

    node_t mem [MAX_NODES];
    node_t rd_data_reg;
    logic  dflt_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_node;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Root reads as the default until the first split is written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_reg <= 1'b0;
        end else if (rd_en) begin
            dflt_reg <= use_dflt && (rd_addr == '0);
        end
    end

    assign rd_node = dflt_reg ? ROOT_DEFAULT : rd_data_reg;

endmodule

>>> design/bspl_side.sv
// Side test of a query point against a split line, exact dot product in two stages.
module bspl_side (
    input  logic                                aclk,
    input  bspl_pkg::node_t                     node,
    input  logic signed [bspl_pkg::COORD_W-1:0] qx,
    input  logic signed [bspl_pkg::COORD_W-1:0] qy,
    output logic                                is_left
);
    import bspl_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + COORD_W;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [SUM_W-1:0]  sum;

    // Position minus query, one bit wider
    assign diff_x = DIFF_W'(node.px) - DIFF_W'(qx);
    assign diff_y = DIFF_W'(node.py) - DIFF_W'(qy);

    // Products registered before the add
    always_ff @(posedge aclk) begin
        prod_x_reg <= PROD_W'(diff_x) * PROD_W'(node.dx);
        prod_y_reg <= PROD_W'(diff_y) * PROD_W'(node.dy);
    end

    // Negative dot product selects the left side
    assign sum     = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg);
    assign is_left = sum[SUM_W-1];

endmodule

>>> design/bsp_split_insert_and_locate.sv
// Top level: 2D BSP tree insert, locate and clear over a node table memory.
// Clear and unused codes go straight to S_DONE; locate and insert walk up to
// DEPTH_LIMIT levels of the tree; a first insert skips the walk.
// Throughput: one item at a time; each level costs a table read and a
// two-stage dot product. A new item is taken while a result waits on m_.
// Reset: count 1, default root, no first split; other entries stay unwritten.
module bsp_split_insert_and_locate #(
    parameter int MAX_NODES   = bspl_pkg::MAX_NODES_DEF,
    parameter int DEPTH_LIMIT = bspl_pkg::DEPTH_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // point_x, point_y, line_dir_x, line_dir_y, left_value, right_value, zero pad
    input  logic [95:0] s_tdata,
    // operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // leaf_value, new_node_index, zero pad
    output logic [31:0] m_tdata,
    // status
    output logic [1:0]  m_tuser
);
    import bspl_pkg::*;

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int DEP_W = $clog2(DEPTH_LIMIT + 1);

    state_t                    state_reg, state_next;
    op_t                       op_reg, op_next;
    logic signed [COORD_W-1:0] qx_reg, qx_next;
    logic signed [COORD_W-1:0] qy_reg, qy_next;
    node_t                     nn_reg, nn_next;
    logic [IDX_W-1:0]          cur_reg, cur_next;
    logic [IDX_W-1:0]          new_addr_reg, new_addr_next;
    logic [DEP_W-1:0]          depth_reg, depth_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      first_done_reg, first_done_next;
    status_t                   res_stat_reg, res_stat_next;
    logic [VAL_W-1:0]          res_leaf_reg, res_leaf_next;
    logic [NIDX_W-1:0]         res_idx_reg, res_idx_next;

    logic                      m_valid_reg;
    logic [31:0]               m_data_reg;
    logic [1:0]                m_user_reg;
    logic                      load_out;

    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    node_t                     rd_node;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    node_t                     wr_node;
    logic                      is_left;
    logic [SLOT_W-1:0]         slot;
    logic [IDX_W-1:0]          link_idx;
    node_t                     par_node;

    bspl_table #(
        .MAX_NODES (MAX_NODES),
        .IDX_W     (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .use_dflt (!first_done_reg),
        .rd_node  (rd_node),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_node  (wr_node)
    );

    bspl_side u_side (
        .aclk    (aclk),
        .node    (rd_node),
        .qx      (qx_reg),
        .qy      (qy_reg),
        .is_left (is_left)
    );

    // Slot taken on this level and where a link points
    assign slot     = is_left ? rd_node.slot_l : rd_node.slot_r;
    assign link_idx = IDX_W'(slot - SLOT_W'(LINK_BASE));

    // Parent with the chosen leaf slot turned into a link to the new node
    always_comb begin
        par_node = rd_node;
        if (is_left) begin
            par_node.slot_l = SLOT_W'(LINK_BASE) + SLOT_W'(count_reg);
        end else begin
            par_node.slot_r = SLOT_W'(LINK_BASE) + SLOT_W'(count_reg);
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= CNT_W'(1);
            first_done_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            first_done_reg <= first_done_next;
        end
    end

    // Item and walk registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        nn_reg       <= nn_next;
        cur_reg      <= cur_next;
        new_addr_reg <= new_addr_next;
        depth_reg    <= depth_next;
        res_stat_reg <= res_stat_next;
        res_leaf_reg <= res_leaf_next;
        res_idx_reg  <= res_idx_next;
    end

    // Sequencer: next state, memory accesses and result
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        nn_next         = nn_reg;
        cur_next        = cur_reg;
        new_addr_next   = new_addr_reg;
        depth_next      = depth_reg;
        count_next      = count_reg;
        first_done_next = first_done_reg;
        res_stat_next   = res_stat_reg;
        res_leaf_next   = res_leaf_reg;
        res_idx_next    = res_idx_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = new_addr_reg;
        wr_node         = nn_reg;
        load_out        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next        = op_t'(s_tuser);
                    qx_next        = s_tdata[15:0];
                    qy_next        = s_tdata[31:16];
                    nn_next.px     = s_tdata[15:0];
                    nn_next.py     = s_tdata[31:16];
                    nn_next.dx     = s_tdata[47:32];
                    nn_next.dy     = s_tdata[63:48];
                    nn_next.slot_l = SLOT_W'(s_tdata[78:64]);
                    nn_next.slot_r = SLOT_W'(s_tdata[93:79]);
                    cur_next       = '0;
                    depth_next     = '0;
                    res_stat_next  = ST_OK;
                    res_leaf_next  = '0;
                    res_idx_next   = '0;
                    // root is fetched for every item
                    rd_en          = 1'b1;
                    rd_addr        = '0;
                    case (op_t'(s_tuser))
                        OP_INSERT: begin
                            if (!first_done_reg) begin
                                new_addr_next = '0;
                                state_next    = S_WNEW;
                            end else if (count_reg >= CNT_W'(MAX_NODES)) begin
                                res_stat_next = ST_FULL;
                                state_next    = S_DONE;
                            end else begin
                                state_next    = S_MUL;
                            end
                        end
                        OP_LOCATE: begin
                            state_next = S_MUL;
                        end
                        OP_CLEAR: begin
                            count_next      = CNT_W'(1);
                            first_done_next = 1'b0;
                            state_next      = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                state_next = S_DEC;
            end
            S_DEC: begin
                if (slot >= SLOT_W'(LINK_BASE)) begin
                    // follow the link, or stop at the depth limit
                    if (depth_reg == DEP_W'(DEPTH_LIMIT - 1)) begin
                        if (op_reg == OP_INSERT) begin
                            res_stat_next = ST_DEEP;
                        end
                        state_next = S_DONE;
                    end else begin
                        depth_next = depth_reg + DEP_W'(1);
                        cur_next   = link_idx;
                        rd_en      = 1'b1;
                        rd_addr    = link_idx;
                        state_next = S_MUL;
                    end
                end else if (op_reg == OP_INSERT) begin
                    // hook the new node into the parent, then write it
                    wr_en         = 1'b1;
                    wr_addr       = cur_reg;
                    wr_node       = par_node;
                    new_addr_next = IDX_W'(count_reg);
                    res_idx_next  = NIDX_W'(count_reg);
                    state_next    = S_WNEW;
                end else begin
                    res_leaf_next = slot[VAL_W-1:0];
                    state_next    = S_DONE;
                end
            end
            S_WNEW: begin
                wr_en = 1'b1;
                if (first_done_reg) begin
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    first_done_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {7'd0, res_idx_reg, res_leaf_reg};
            m_user_reg <= res_stat_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // node count stays within the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(MAX_NODES)))
        else $error("node count out of range");

    // a parent update is always followed by the new node write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DEC && wr_en) |=> (state_reg == S_WNEW))
        else $error("parent written without new node");

    // a linked insert grows the table by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WNEW && first_done_reg) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("node count not advanced");

    // walk never passes the depth limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL || state_reg == S_DEC) |->
            (depth_reg < DEP_W'(DEPTH_LIMIT)))
        else $error("walk deeper than limit");
`endif

endmodule

>>> sim/bsp_split_insert_and_locate_tb.sv
// Self-checking testbench for the BSP split insert and locate block.
`timescale 1ns / 1ps

module bsp_split_insert_and_locate_tb;
    import bspl_pkg::*;

    localparam int MAX_NODES      = MAX_NODES_DEF;
    localparam int DEPTH_LIMIT    = DEPTH_LIMIT_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 150;
    localparam int HOLD_AT        = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int CALM_LO        = 400;
    localparam int CALM_HI        = 700;

    // One input item and one result item
    typedef struct packed {
        op_t               op;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [14:0]       lval;
        logic [14:0]       rval;
    } bsp_item_t;

    typedef struct packed {
        status_t     status;
        logic [14:0] leaf;
        logic [9:0]  idx;
    } bsp_result_t;

    // Shadow copy of the split tree
    typedef struct {
        int          px;
        int          py;
        int          dx;
        int          dy;
        int unsigned slot [2];
    } split_node_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    split_node_t tree_nodes [MAX_NODES];
    int unsigned tree_count;
    bit          root_split;

    bsp_item_t   pending_q [$];
    bsp_result_t expected_q [$];
    logic [31:0] split_pts_q [$];
    bsp_item_t   cur_item;
    bsp_result_t exp_r;

    int total_items;
    int sent_cnt;
    int rcv_cnt;
    int fail_cnt;
    int stall_cycles;
    int hold_left;
    bit hold_done;

    bsp_split_insert_and_locate uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Tree back to its default root: pos (0.5, 0.5), dir (1, 1)
    function automatic void tree_reset();
        for (int i = 0; i < MAX_NODES; i++) begin
            tree_nodes[i].px      = 0;
            tree_nodes[i].py      = 0;
            tree_nodes[i].dx      = 0;
            tree_nodes[i].dy      = 0;
            tree_nodes[i].slot[0] = 0;
            tree_nodes[i].slot[1] = 0;
        end
        tree_nodes[0].px = 8192;
        tree_nodes[0].py = 8192;
        tree_nodes[0].dx = 16384;
        tree_nodes[0].dy = 16384;
        tree_count = 1;
        root_split = 1'b0;
    endfunction

    // 0 = left (dot product negative), 1 = right
    function automatic int unsigned side_of(int unsigned n, int qx, int qy);
        longint d;
        d = longint'(tree_nodes[n].px - qx) * tree_nodes[n].dx +
            longint'(tree_nodes[n].py - qy) * tree_nodes[n].dy;
        return (d < 0) ? 0 : 1;
    endfunction

    // Applies one item to the shadow tree and returns the result it gives
    function automatic bsp_result_t walk_tree(bsp_item_t it);
        bsp_result_t r;
        split_node_t nn;
        int          qx;
        int          qy;
        int unsigned cur;
        int unsigned s;
        int unsigned v;
        r        = '0;
        r.status = ST_OK;
        qx       = int'(it.px);
        qy       = int'(it.py);
        cur      = 0;
        if (it.op == OP_INSERT) begin
            nn.px      = qx;
            nn.py      = qy;
            nn.dx      = int'(it.dx);
            nn.dy      = int'(it.dy);
            nn.slot[0] = it.lval;
            nn.slot[1] = it.rval;
            if (!root_split) begin
                tree_nodes[0] = nn;
                root_split    = 1'b1;
            end else if (tree_count >= MAX_NODES) begin
                r.status = ST_FULL;
            end else begin
                r.status = ST_DEEP;
                for (int lvl = 0; lvl < DEPTH_LIMIT; lvl++) begin
                    s = side_of(cur, qx, qy);
                    if (tree_nodes[cur].slot[s] >= LINK_BASE) begin
                        cur = (tree_nodes[cur].slot[s] - LINK_BASE) % MAX_NODES;
                    end else begin
                        tree_nodes[cur].slot[s] = tree_count + LINK_BASE;
                        tree_nodes[tree_count]  = nn;
                        r.idx                   = 10'(tree_count);
                        tree_count++;
                        r.status = ST_OK;
                        break;
                    end
                end
            end
        end else if (it.op == OP_LOCATE) begin
            for (int lvl = 0; lvl < DEPTH_LIMIT; lvl++) begin
                v = tree_nodes[cur].slot[side_of(cur, qx, qy)];
                if (v >= LINK_BASE) begin
                    cur = (v - LINK_BASE) % MAX_NODES;
                end else begin
                    r.leaf = 15'(v);
                    break;
                end
            end
        end else if (it.op == OP_CLEAR) begin
            tree_reset();
        end
        return r;
    endfunction

    // Coordinate with extra weight on the range ends
    function automatic logic [15:0] rnd_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 16'h8000;
        if (r < 6) return 16'h7FFF;
        if (r < 8) return 16'h0000;
        if (r < 10) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic add_item(op_t op, logic [15:0] px, logic [15:0] py, logic [15:0] dx,
                            logic [15:0] dy, logic [14:0] lv, logic [14:0] rv);
        bsp_item_t it;
        it.op   = op;
        it.px   = px;
        it.py   = py;
        it.dx   = dx;
        it.dy   = dy;
        it.lval = lv;
        it.rval = rv;
        pending_q.insert(pending_q.size(), it);
        if (op == OP_INSERT)
            split_pts_q.insert(split_pts_q.size(), {py, px});
    endtask

    task automatic add_rnd_insert();
        add_item(OP_INSERT, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 15'($urandom), 15'($urandom));
    endtask

    // Half the queries land exactly on a known split position
    task automatic add_rnd_locate();
        logic [31:0] pt;
        if (split_pts_q.size() != 0 && $urandom_range(0, 1) == 1)
            pt = split_pts_q[$urandom_range(0, split_pts_q.size() - 1)];
        else
            pt = {rnd_coord(), rnd_coord()};
        add_item(OP_LOCATE, pt[15:0], pt[31:16], 16'($urandom), 16'($urandom),
                 15'($urandom), 15'($urandom));
    endtask

    // Chain of splits through one point, long enough to pass the depth limit
    task automatic add_deep_chain();
        logic [15:0] cx;
        logic [15:0] cy;
        cx = rnd_coord();
        cy = rnd_coord();
        add_item(OP_CLEAR, '0, '0, '0, '0, '0, '0);
        add_rnd_insert();
        for (int i = 0; i < DEPTH_LIMIT + 2; i++)
            add_item(OP_INSERT, cx, cy, rnd_coord(), rnd_coord(),
                     15'($urandom), 15'($urandom));
        add_item(OP_LOCATE, cx, cy, '0, '0, '0, '0);
        for (int i = 0; i < 3; i++)
            add_rnd_locate();
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Input driver: offers queued items, idles now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.insert(expected_q.size(), walk_tree(cur_item));
                sent_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 &&
                    ((sent_cnt >= CALM_LO && sent_cnt < CALM_HI) ||
                     $urandom_range(0, 99) >= 7)) begin
                    cur_item = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, cur_item.rval, cur_item.lval, cur_item.dy,
                                 cur_item.dx, cur_item.py, cur_item.px};
                    s_tuser  <= cur_item.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each result with the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                rcv_cnt++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result: status %0d leaf_value %0d new_node_index %0d",
                           m_tuser, m_tdata[14:0], m_tdata[24:15]);
                    fail_cnt++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_tuser !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tdata[14:0] !== exp_r.leaf) begin
                        $error("leaf_value: expected %0d, got %0d", exp_r.leaf,
                               m_tdata[14:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[24:15] !== exp_r.idx) begin
                        $error("new_node_index: expected %0d, got %0d", exp_r.idx,
                               m_tdata[24:15]);
                        fail_cnt++;
                    end
                end
            end
            // one long hold-off so the block backs up its input
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rcv_cnt >= HOLD_AT && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (rcv_cnt >= CALM_LO && rcv_cnt < CALM_HI) ||
                            $urandom_range(0, 99) >= 7;
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("bsp_split_insert_and_locate_tb: FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int r;
        tree_reset();

        // directed: default root, first insert, extremes, zero direction, clears
        add_item(OP_LOCATE, 16'h0000, 16'h0000, '0, '0, '0, '0);
        add_item(OP_LOCATE, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
        add_item(OP_INSERT, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 15'h7FFF, 15'h0000);
        add_item(OP_LOCATE, 16'h7FFF, 16'h8000, '0, '0, '0, '0);
        add_item(OP_LOCATE, 16'h8000, 16'h7FFF, '0, '0, '0, '0);
        add_item(OP_INSERT, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 15'h0001, 15'h5555);
        add_item(OP_INSERT, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 15'h2AAA, 15'h7FFE);
        add_item(OP_INSERT, 16'h4000, 16'hC000, 16'h4000, 16'h0000, 15'h0003, 15'h0004);
        add_item(OP_LOCATE, 16'h0000, 16'h0000, '0, '0, '0, '0);
        add_item(OP_LOCATE, 16'h7FFF, 16'h8000, '0, '0, '0, '0);
        add_item(OP_LOCATE, 16'h8000, 16'h8000, '0, '0, '0, '0);
        add_item(OP_LOCATE, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0);
        add_item(OP_LOCATE, 16'h4000, 16'hC000, '0, '0, '0, '0);
        add_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
        add_item(OP_LOCATE, 16'h0000, 16'h0000, '0, '0, '0, '0);
        add_item(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, 15'h0011, 15'h0022);
        add_item(OP_INSERT, 16'h1000, 16'h2000, 16'hF000, 16'h0100, 15'h0033, 15'h0044);
        add_item(OP_LOCATE, 16'h1000, 16'h2000, '0, '0, '0, '0);
        add_item(OP_CLEAR, '0, '0, '0, '0, '0, '0);
        add_item(OP_CLEAR, '0, '0, '0, '0, '0, '0);
        add_item(OP_INSERT, 16'h2000, 16'h2000, 16'h4000, 16'h4000, 15'h0055, 15'h0066);
        add_item(OP_LOCATE, 16'h2000, 16'h2000, '0, '0, '0, '0);

        // mostly inserts, toward a full table, with queries mixed in
        add_item(OP_CLEAR, '0, '0, '0, '0, '0, '0);
        for (int i = 0; i < 1100; i++) begin
            if ($urandom_range(0, 99) < 93)
                add_rnd_insert();
            else
                add_rnd_locate();
        end

        // chains through one point hit the depth limit on insert and locate
        add_deep_chain();
        add_deep_chain();

        // mixed traffic with clears keeping trees small
        for (int i = 0; i < 380; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                add_rnd_insert();
            else if (r < 96)
                add_rnd_locate();
            else
                add_item(OP_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         15'($urandom), 15'($urandom));
        end
        total_items = pending_q.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (rcv_cnt < total_items) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("bsp_split_insert_and_locate_tb: PASS");
        else
            $display("bsp_split_insert_and_locate_tb: FAIL");
        $finish;
    end

endmodule
